[design/cpr_pkg.sv]
// Package for the collinear point reducer: word types, widths and fixed constants.
// Used by cpr_mul, collinear_point_reducer and cpr_assert; depends on nothing else.
package cpr_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int TIME_WIDTH    = 32;
    localparam int THR_WIDTH     = 16;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd256;

    // The squared Q8.8 threshold carries 16 fraction bits.
    localparam int THR_SQ_WIDTH  = 2 * THR_WIDTH;
    localparam int Q_SHIFT       = 16;

    // Line coefficients and the signed accumulator for residuals and C.
    localparam int AB_WIDTH      = COORD_WIDTH + 1;
    localparam int C_WIDTH       = 2 * COORD_WIDTH + 1;
    localparam int SUM_WIDTH     = 2 * COORD_WIDTH + 2;

    // Shared multiplier: operand widths and digit-serial schedule.
    localparam int MUL_WIDTH     = (SUM_WIDTH > THR_SQ_WIDTH) ? SUM_WIDTH : THR_SQ_WIDTH;
    localparam int DIGIT_WIDTH   = 16;
    localparam int MUL_DIGITS    = (MUL_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int MUL_B_WIDTH   = MUL_DIGITS * DIGIT_WIDTH;
    localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
    localparam int MUL_CNT_WIDTH = $clog2(MUL_DIGITS + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t                  point_x;
        coord_t                  point_y;
        logic [TIME_WIDTH-1:0]   point_time;
        logic                    end_of_stream;
    } point_word_t;

    typedef struct packed {
        coord_t                  kept_x;
        coord_t                  kept_y;
        logic [TIME_WIDTH-1:0]   kept_time;
        logic                    final_vertex;
    } vertex_word_t;

    typedef struct packed {
        logic                    start;
        logic [MUL_WIDTH-1:0]    op_a;
        logic [MUL_WIDTH-1:0]    op_b;
    } mul_req_t;

endpackage

[design/cpr_mul.sv]
// Digit-serial unsigned multiplier shared by all products of the reducer.
// Depends on cpr_pkg for operand widths and the digit schedule.
module cpr_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cpr_pkg::mul_req_t                 req,
    output logic                              done,
    output logic [cpr_pkg::PROD_WIDTH-1:0]    product
);

    logic [cpr_pkg::MUL_WIDTH-1:0]     a_reg, a_next;
    logic [cpr_pkg::MUL_B_WIDTH-1:0]   b_reg, b_next;
    logic [cpr_pkg::PROD_WIDTH-1:0]    acc_reg, acc_next;
    logic [cpr_pkg::MUL_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                              done_reg, done_next;
    logic [cpr_pkg::DIGIT_WIDTH-1:0]   digit;
    logic [cpr_pkg::MUL_WIDTH+cpr_pkg::DIGIT_WIDTH-1:0] partial;

    // Most significant digit of b first, so the accumulator only shifts left by one digit.
    assign digit   = b_reg[cpr_pkg::MUL_B_WIDTH-1 -: cpr_pkg::DIGIT_WIDTH];
    assign partial = a_reg * digit;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next   = req.op_a;
            b_next   = cpr_pkg::MUL_B_WIDTH'(req.op_b);
            acc_next = '0;
            cnt_next = cpr_pkg::MUL_CNT_WIDTH'(cpr_pkg::MUL_DIGITS);
        end else if (cnt_reg != '0) begin
            acc_next  = (acc_reg << cpr_pkg::DIGIT_WIDTH)
                        + cpr_pkg::PROD_WIDTH'(partial);
            b_next    = b_reg << cpr_pkg::DIGIT_WIDTH;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == cpr_pkg::MUL_CNT_WIDTH'(1));
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[design/collinear_point_reducer.sv]
// Top level of the collinear point reducer: sequencer, state and output register.
// Depends on cpr_pkg and instantiates the shared multiplier cpr_mul.
//
// The block thins a stream of timestamped points. Points arrive as words on the
// s_ channel (valid/ready); a word with end_of_stream set closes the stream. Kept
// vertices leave as words on the m_ channel, the last one of a stream marked with
// final_vertex. The cfg_ channel writes the Q8.8 distance threshold; it is always
// ready and must only be used while the block is idle.
//
// One input word is handled at a time. s_ready is high only in the idle state.
// A point that is a duplicate, starts a stream or only closes it passes from the
// decide state to the finish state and back to idle. A point tested against the
// current line runs seven products through the shared multiplier, which takes its
// operand in 16-bit digits (three digits at 16-bit coordinates). A point that
// breaks the line adds two more products for the new line constant. The second
// point of a stream runs only those two products.
//
// Results sit in a single output register. When the receiver stalls, the
// sequencer waits before loading the next vertex, so nothing is lost. Synchronous
// active-low reset empties the output register, clears the stream state and sets
// the threshold back to 1.0 pixel.
module collinear_point_reducer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cpr_pkg::point_word_t           s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cpr_pkg::vertex_word_t          m_word,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cpr_pkg::THR_WIDTH-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_EMIT_BRK,
        ST_LINE,
        ST_FINISH
    } state_t;

    // One code per product; the order follows the sequence of the line test.
    typedef enum logic [3:0] {
        U_AX,
        U_BY,
        U_RR,
        U_AA,
        U_BB,
        U_TT,
        U_ST,
        U_CX,
        U_CY
    } uop_t;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_ONE,
        PH_TWO
    } phase_t;

    localparam int CW = cpr_pkg::COORD_WIDTH;

    state_t                              state_reg, state_next;
    uop_t                                uop_reg, uop_next;
    phase_t                              phase_reg, phase_next;
    cpr_pkg::point_word_t                in_word_reg, in_word_next;
    cpr_pkg::coord_t                     prev_x_reg, prev_x_next;
    cpr_pkg::coord_t                     prev_y_reg, prev_y_next;
    logic [cpr_pkg::TIME_WIDTH-1:0]      prev_time_reg, prev_time_next;
    logic signed [cpr_pkg::AB_WIDTH-1:0] line_a_reg, line_a_next;
    logic signed [cpr_pkg::AB_WIDTH-1:0] line_b_reg, line_b_next;
    logic signed [cpr_pkg::C_WIDTH-1:0]  line_c_reg, line_c_next;
    logic signed [cpr_pkg::SUM_WIDTH-1:0] sum_reg, sum_next;
    logic [cpr_pkg::SUM_WIDTH-1:0]       s_reg, s_next;
    logic [cpr_pkg::THR_SQ_WIDTH-1:0]    t2_reg, t2_next;
    logic [cpr_pkg::PROD_WIDTH-1:0]      r2_reg, r2_next;
    logic [cpr_pkg::THR_WIDTH-1:0]       thr_reg, thr_next;
    logic                                m_valid_reg, m_valid_next;
    cpr_pkg::vertex_word_t               m_word_reg, m_word_next;

    cpr_pkg::mul_req_t                   mul_req;
    logic                                mul_done;
    logic [cpr_pkg::PROD_WIDTH-1:0]      mul_product;

    logic [CW-1:0]                       mag_in_x, mag_in_y, mag_prev_x, mag_prev_y;
    logic [cpr_pkg::AB_WIDTH-1:0]        mag_a, mag_b;
    logic [cpr_pkg::SUM_WIDTH-1:0]       mag_sum;
    logic                                prod_neg;
    logic [cpr_pkg::SUM_WIDTH-1:0]       prod_low, prod_term;
    logic                                breaks;
    logic                                out_free;
    logic                                same_point;

    cpr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    // Magnitudes of the signed operands; products are formed unsigned and the
    // sign is applied when the result is accumulated.
    assign mag_in_x   = in_word_reg.point_x[CW-1] ? CW'(-in_word_reg.point_x)
                                                   : CW'(in_word_reg.point_x);
    assign mag_in_y   = in_word_reg.point_y[CW-1] ? CW'(-in_word_reg.point_y)
                                                   : CW'(in_word_reg.point_y);
    assign mag_prev_x = prev_x_reg[CW-1] ? CW'(-prev_x_reg) : CW'(prev_x_reg);
    assign mag_prev_y = prev_y_reg[CW-1] ? CW'(-prev_y_reg) : CW'(prev_y_reg);
    assign mag_a      = line_a_reg[cpr_pkg::AB_WIDTH-1]
                        ? cpr_pkg::AB_WIDTH'(-line_a_reg) : cpr_pkg::AB_WIDTH'(line_a_reg);
    assign mag_b      = line_b_reg[cpr_pkg::AB_WIDTH-1]
                        ? cpr_pkg::AB_WIDTH'(-line_b_reg) : cpr_pkg::AB_WIDTH'(line_b_reg);
    assign mag_sum    = sum_reg[cpr_pkg::SUM_WIDTH-1]
                        ? cpr_pkg::SUM_WIDTH'(-sum_reg) : cpr_pkg::SUM_WIDTH'(sum_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_req.start = (state_reg == ST_MUL_GO);
        mul_req.op_a  = '0;
        mul_req.op_b  = '0;
        prod_neg      = 1'b0;
        case (uop_reg)
            U_AX: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_a);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_in_x);
                prod_neg     = line_a_reg[cpr_pkg::AB_WIDTH-1] ^ in_word_reg.point_x[CW-1];
            end
            U_BY: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_b);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_in_y);
                prod_neg     = line_b_reg[cpr_pkg::AB_WIDTH-1] ^ in_word_reg.point_y[CW-1];
            end
            U_RR: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_sum);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_sum);
            end
            U_AA: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_a);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_a);
            end
            U_BB: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_b);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_b);
            end
            U_TT: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(thr_reg);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(thr_reg);
            end
            U_ST: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(s_reg);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(t2_reg);
            end
            U_CX: begin
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_in_x);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_prev_y);
                prod_neg     = in_word_reg.point_x[CW-1] ^ prev_y_reg[CW-1];
            end
            U_CY: begin
                // Subtracted term of C, so the sign is flipped once more.
                mul_req.op_a = cpr_pkg::MUL_WIDTH'(mag_prev_x);
                mul_req.op_b = cpr_pkg::MUL_WIDTH'(mag_in_y);
                prod_neg     = ~(prev_x_reg[CW-1] ^ in_word_reg.point_y[CW-1]);
            end
            default: begin
                mul_req.op_a = '0;
            end
        endcase
    end

    assign prod_low  = mul_product[cpr_pkg::SUM_WIDTH-1:0];
    assign prod_term = prod_neg ? (~prod_low + 1'b1) : prod_low;

    // The squared residual, scaled by the 16 fraction bits of T^2, against
    // (A^2 + B^2) T^2. Both sides are exact, so no rounding enters the test.
    assign breaks = {r2_reg, {cpr_pkg::Q_SHIFT{1'b0}}}
                    > {{cpr_pkg::Q_SHIFT{1'b0}}, mul_product};

    assign out_free   = !m_valid_reg || m_ready;
    assign same_point = (in_word_reg.point_x == prev_x_reg)
                        && (in_word_reg.point_y == prev_y_reg);

    always_comb begin
        state_next     = state_reg;
        uop_next       = uop_reg;
        phase_next     = phase_reg;
        in_word_next   = in_word_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_time_next = prev_time_reg;
        line_a_next    = line_a_reg;
        line_b_next    = line_b_reg;
        line_c_next    = line_c_reg;
        sum_next       = sum_reg;
        s_next         = s_reg;
        t2_next        = t2_reg;
        r2_next        = r2_reg;
        thr_next       = thr_reg;
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;

        if (cfg_valid && cfg_ready) begin
            thr_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_word_next = s_word;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (phase_reg)
                    PH_ONE: begin
                        state_next = same_point ? ST_FINISH : ST_EMIT_BRK;
                    end
                    PH_TWO: begin
                        uop_next   = U_AX;
                        state_next = same_point ? ST_FINISH : ST_MUL_GO;
                    end
                    default: begin
                        // Nothing kept yet: this point opens the stream.
                        prev_x_next    = in_word_reg.point_x;
                        prev_y_next    = in_word_reg.point_y;
                        prev_time_next = in_word_reg.point_time;
                        phase_next     = PH_ONE;
                        state_next     = ST_FINISH;
                    end
                endcase
            end
            ST_MUL_GO: begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = ST_MUL_GO;
                    case (uop_reg)
                        U_AX: begin
                            sum_next = cpr_pkg::SUM_WIDTH'(line_c_reg) + $signed(prod_term);
                            uop_next = U_BY;
                        end
                        U_BY: begin
                            sum_next = sum_reg + $signed(prod_term);
                            uop_next = U_RR;
                        end
                        U_RR: begin
                            r2_next  = mul_product;
                            uop_next = U_AA;
                        end
                        U_AA: begin
                            s_next   = mul_product[cpr_pkg::SUM_WIDTH-1:0];
                            uop_next = U_BB;
                        end
                        U_BB: begin
                            s_next   = s_reg + mul_product[cpr_pkg::SUM_WIDTH-1:0];
                            uop_next = U_TT;
                        end
                        U_TT: begin
                            t2_next  = mul_product[cpr_pkg::THR_SQ_WIDTH-1:0];
                            uop_next = U_ST;
                        end
                        U_ST: begin
                            if (breaks) begin
                                state_next = ST_EMIT_BRK;
                            end else begin
                                prev_x_next    = in_word_reg.point_x;
                                prev_y_next    = in_word_reg.point_y;
                                prev_time_next = in_word_reg.point_time;
                                state_next     = ST_FINISH;
                            end
                        end
                        U_CX: begin
                            sum_next = $signed(prod_term);
                            uop_next = U_CY;
                        end
                        U_CY: begin
                            sum_next   = sum_reg + $signed(prod_term);
                            state_next = ST_LINE;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_EMIT_BRK: begin
                // The previous point becomes a vertex before the new line replaces it.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = '{kept_x: prev_x_reg, kept_y: prev_y_reg,
                                     kept_time: prev_time_reg, final_vertex: 1'b0};
                    uop_next     = U_CX;
                    state_next   = ST_MUL_GO;
                end
            end
            ST_LINE: begin
                line_a_next    = cpr_pkg::AB_WIDTH'(in_word_reg.point_y)
                                 - cpr_pkg::AB_WIDTH'(prev_y_reg);
                line_b_next    = cpr_pkg::AB_WIDTH'(prev_x_reg)
                                 - cpr_pkg::AB_WIDTH'(in_word_reg.point_x);
                line_c_next    = sum_reg[cpr_pkg::C_WIDTH-1:0];
                prev_x_next    = in_word_reg.point_x;
                prev_y_next    = in_word_reg.point_y;
                prev_time_next = in_word_reg.point_time;
                phase_next     = PH_TWO;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (!in_word_reg.end_of_stream) begin
                    state_next = ST_IDLE;
                end else if (phase_reg != PH_TWO) begin
                    phase_next = PH_NONE;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = '{kept_x: prev_x_reg, kept_y: prev_y_reg,
                                     kept_time: prev_time_reg, final_vertex: 1'b1};
                    phase_next   = PH_NONE;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        in_word_reg   <= in_word_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        prev_time_reg <= prev_time_next;
        line_a_reg    <= line_a_next;
        line_b_reg    <= line_b_next;
        line_c_reg    <= line_c_next;
        sum_reg       <= sum_next;
        s_reg         <= s_next;
        t2_reg        <= t2_next;
        r2_reg        <= r2_next;
        m_word_reg    <= m_word_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            uop_reg     <= U_AX;
            phase_reg   <= PH_NONE;
            thr_reg     <= cpr_pkg::THR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            uop_reg     <= uop_next;
            phase_reg   <= phase_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_word    = m_word_reg;
    assign cfg_ready = 1'b1;

endmodule

[design/cpr_assert.sv]
// Port-level checks for the collinear point reducer, bound to the top level.
// Depends on cpr_pkg for the word types and on collinear_point_reducer for the bind.
module cpr_assert (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input cpr_pkg::point_word_t           s_word,
    input logic                           m_valid,
    input logic                           m_ready,
    input cpr_pkg::vertex_word_t          m_word,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [cpr_pkg::THR_WIDTH-1:0]  cfg_data
);

    // A stalled output word holds its place and its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("output word changed or dropped while stalled");

    // Every accepted word keeps the input closed until it has been decided and finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened too early after an accepted word");

    // With no word in progress and the output empty, no vertex can appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid && !m_valid |=> !m_valid)
        else $error("vertex produced while idle");

    // The threshold register never pushes back on a write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind collinear_point_reducer cpr_assert u_cpr_assert (.*);
